// File: hdl/vlc_flc_pkg.sv
// Shared types and constants for the VLC PHY frame-length calculator.
// Holds field widths, code selectors and reciprocal constants; no dependencies.
`timescale 1ns / 1ps

package vlc_flc_pkg;

  // Payload length field and derived datapath widths
  localparam int RAW_LENGTH_BITS = 20;
  localparam int W_W             = RAW_LENGTH_BITS - 1;   // RS word count
  localparam int RECIP_SHIFT     = W_W;
  localparam int PROD_W          = 2 * W_W;
  localparam int K_W             = 8;                     // k and n of the RS code
  localparam int R_W             = K_W + 1;               // remainder estimate, below 2k
  localparam int SYM_W           = W_W + K_W + 1;
  localparam int BITS_W          = RAW_LENGTH_BITS + 4;
  localparam int CC_W            = BITS_W + 2;
  localparam int LEN_W           = CC_W + 4;
  localparam int OUT_W           = 25;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Scaled reciprocals of the data-word counts; exact for powers of two
  localparam logic [W_W-1:0] RECIP_2   = W_W'((64'd1 << RECIP_SHIFT) / 2);
  localparam logic [W_W-1:0] RECIP_4   = W_W'((64'd1 << RECIP_SHIFT) / 4);
  localparam logic [W_W-1:0] RECIP_7   = W_W'((64'd1 << RECIP_SHIFT) / 7);
  localparam logic [W_W-1:0] RECIP_11  = W_W'((64'd1 << RECIP_SHIFT) / 11);
  localparam logic [W_W-1:0] RECIP_32  = W_W'((64'd1 << RECIP_SHIFT) / 32);
  localparam logic [W_W-1:0] RECIP_128 = W_W'((64'd1 << RECIP_SHIFT) / 128);

  // Outer Reed-Solomon code selection
  typedef enum logic [2:0] {
    RS_NONE,
    RS_15_2,
    RS_15_4,
    RS_15_7,
    RS_15_11,
    RS_64_32,
    RS_160_128
  } rs_e;

  // Inner convolutional code ratio (out/in)
  typedef enum logic [1:0] {
    CC_NONE,
    CC_4_1,
    CC_3_1,
    CC_3_2
  } cc_e;

  // Line code expansion
  typedef enum logic [1:0] {
    LINE_X2,
    LINE_6_4,
    LINE_10_8
  } line_e;

  typedef struct packed {
    rs_e   rs;
    logic  word8;
    cc_e   cc;
    line_e line;
  } ctl_t;

endpackage

// File: hdl/vlc_phy_frame_length_calc.sv
// Top level of the VLC PHY frame-length calculator: seven-stage datapath.
// Depends on vlc_flc_pkg for widths, code selectors and reciprocals.
// Throughput: one length per cycle; busy_o stays low, the reciprocal
// multiply for the RS division is fully pipelined. The receiver cannot stall.
// Reset (rst_ni, asynchronous, active low) clears the stage valid bits only.
`timescale 1ns / 1ps

module vlc_phy_frame_length_calc (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  output logic                                      busy_o,
  input  logic                                      phy_kind_i,
  input  logic                                      modulation_i,
  input  logic [3:0]                                mode_index_i,
  input  logic [vlc_flc_pkg::RAW_LENGTH_BITS-1:0]   raw_length_i,
  output logic                                      done_o,
  output logic [vlc_flc_pkg::OUT_W-1:0]             coded_length_o
);
  import vlc_flc_pkg::*;

  // Data words per codeword
  function automatic logic [K_W-1:0] rs_k(rs_e rs);
    logic [K_W-1:0] k;
    unique case (rs)
      RS_15_2:    k = K_W'(2);
      RS_15_4:    k = K_W'(4);
      RS_15_7:    k = K_W'(7);
      RS_15_11:   k = K_W'(11);
      RS_64_32:   k = K_W'(32);
      RS_160_128: k = K_W'(128);
      default:    k = '0;
    endcase
    return k;
  endfunction

  // Total words per codeword
  function automatic logic [K_W-1:0] rs_n(rs_e rs);
    logic [K_W-1:0] n;
    unique case (rs)
      RS_15_2, RS_15_4, RS_15_7, RS_15_11: n = K_W'(15);
      RS_64_32:   n = K_W'(64);
      RS_160_128: n = K_W'(160);
      default:    n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [W_W-1:0] rs_recip(rs_e rs);
    logic [W_W-1:0] m;
    unique case (rs)
      RS_15_2:    m = RECIP_2;
      RS_15_4:    m = RECIP_4;
      RS_15_7:    m = RECIP_7;
      RS_15_11:   m = RECIP_11;
      RS_64_32:   m = RECIP_32;
      RS_160_128: m = RECIP_128;
      default:    m = '0;
    endcase
    return m;
  endfunction

  logic [6:0]                 vld_q, vld_d;

  ctl_t                       ctl1_q, ctl1_d, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q;
  logic [W_W-1:0]             w1_q, w1_d, w2_q;
  logic [RAW_LENGTH_BITS-1:0] raw1_q, raw2_q, raw3_q, raw4_q;
  logic [PROD_W-1:0]          prod2_d, prod2_q;
  logic [W_W-1:0]             q3_d, q3_q, q4_d, q4_q;
  logic [R_W-1:0]             r3_d, r3_q;
  logic [K_W-1:0]             r4_d, r4_q;
  logic [BITS_W-1:0]          bits5_d, bits5_q;
  logic [CC_W-1:0]            cc6_d, cc6_q;
  logic [OUT_W-1:0]           len_d, len_q;

  // Stage 1: decode the code set and count RS words
  logic [RAW_LENGTH_BITS:0]   raw_round;

  always_comb begin
    ctl1_d.rs    = RS_NONE;
    ctl1_d.cc    = CC_NONE;
    ctl1_d.word8 = phy_kind_i;
    ctl1_d.line  = LINE_X2;
    if (!phy_kind_i) begin
      if (!modulation_i) begin
        ctl1_d.line = LINE_X2;
        unique case (mode_index_i)
          4'd0: begin
            ctl1_d.rs = RS_15_7;
            ctl1_d.cc = CC_4_1;
          end
          4'd1: begin
            ctl1_d.rs = RS_15_11;
            ctl1_d.cc = CC_3_1;
          end
          4'd2: begin
            ctl1_d.rs = RS_15_11;
            ctl1_d.cc = CC_3_2;
          end
          4'd3: ctl1_d.rs = RS_15_11;
          default: ctl1_d.rs = RS_NONE;
        endcase
      end else begin
        ctl1_d.line = LINE_6_4;
        unique case (mode_index_i)
          4'd0:    ctl1_d.rs = RS_15_2;
          4'd1:    ctl1_d.rs = RS_15_4;
          4'd2:    ctl1_d.rs = RS_15_7;
          default: ctl1_d.rs = RS_NONE;
        endcase
      end
    end else begin
      ctl1_d.line = modulation_i ? LINE_6_4 : LINE_10_8;
      if (!mode_index_i[3]) begin
        ctl1_d.rs = mode_index_i[0] ? RS_160_128 : RS_64_32;
      end
    end

    // Round the bit count up to whole 4-bit or 8-bit words
    if (phy_kind_i) begin
      raw_round = {1'b0, raw_length_i} + (RAW_LENGTH_BITS+1)'(7);
      w1_d      = W_W'(raw_round >> 3);
    end else begin
      raw_round = {1'b0, raw_length_i} + (RAW_LENGTH_BITS+1)'(3);
      w1_d      = W_W'(raw_round >> 2);
    end
  end

  // Stage 2: multiply by the scaled reciprocal of k
  assign prod2_d = PROD_W'(w1_q) * PROD_W'(rs_recip(ctl1_q.rs));

  // Stage 3: quotient estimate, at most one short, and its remainder
  logic [W_W+K_W-1:0] qk3;
  logic [W_W+K_W-1:0] rdiff3;

  always_comb begin
    q3_d   = prod2_q[PROD_W-1:RECIP_SHIFT];
    qk3    = (W_W+K_W)'(q3_d) * (W_W+K_W)'(rs_k(ctl2_q.rs));
    rdiff3 = (W_W+K_W)'(w2_q) - qk3;
    r3_d   = rdiff3[R_W-1:0];
  end

  // Stage 4: correct the quotient when the remainder reaches k
  logic [R_W-1:0] k4;
  logic [R_W-1:0] rsub4;

  always_comb begin
    k4    = R_W'(rs_k(ctl3_q.rs));
    rsub4 = r3_q - k4;
    if (r3_q >= k4) begin
      q4_d = q3_q + W_W'(1);
      r4_d = rsub4[K_W-1:0];
    end else begin
      q4_d = q3_q;
      r4_d = r3_q[K_W-1:0];
    end
  end

  // Stage 5: coded bits, shortening a partial last codeword; raw length if no RS
  logic [SYM_W-1:0]   sym5;
  logic [SYM_W+2:0]   sym5_bits;
  logic [K_W-1:0]     n5;
  logic [K_W-1:0]     k5;

  always_comb begin
    n5   = rs_n(ctl4_q.rs);
    k5   = rs_k(ctl4_q.rs);
    sym5 = SYM_W'(q4_q) * SYM_W'(n5);
    if (r4_q != '0) begin
      sym5 = sym5 + SYM_W'(r4_q) + SYM_W'(n5 - k5);
    end
    if (ctl4_q.word8) begin
      sym5_bits = (SYM_W+3)'(sym5) << 3;
    end else begin
      sym5_bits = (SYM_W+3)'(sym5) << 2;
    end
    if (ctl4_q.rs == RS_NONE) begin
      bits5_d = BITS_W'(raw4_q);
    end else begin
      bits5_d = sym5_bits[BITS_W-1:0];
    end
  end

  // Stage 6: convolutional code with tail bits
  logic [CC_W-1:0] tail6;
  logic [CC_W-1:0] tail6_x3;

  always_comb begin
    tail6    = CC_W'(bits5_q) + CC_W'(6);
    tail6_x3 = tail6 + (tail6 << 1);
    unique case (ctl5_q.cc)
      CC_NONE: cc6_d = CC_W'(bits5_q);
      CC_4_1:  cc6_d = tail6 << 2;
      CC_3_1:  cc6_d = tail6_x3;
      CC_3_2:  cc6_d = tail6_x3 >> 1;
      default: cc6_d = CC_W'(bits5_q);
    endcase
  end

  // Stage 7: line code expansion and saturation
  logic [LEN_W-1:0] ext7;
  logic [LEN_W-1:0] line7;

  always_comb begin
    ext7 = LEN_W'(cc6_q);
    unique case (ctl6_q.line)
      LINE_X2:   line7 = ext7 << 1;
      LINE_6_4:  line7 = ((ext7 << 2) + (ext7 << 1)) >> 2;
      LINE_10_8: line7 = ((ext7 << 3) + (ext7 << 1)) >> 3;
      default:   line7 = ext7 << 1;
    endcase
    if (line7 > LEN_W'(OUT_MAX)) begin
      len_d = OUT_MAX;
    end else begin
      len_d = line7[OUT_W-1:0];
    end
  end

  // Shift the valid bits along unconditionally; start_i enters at bit 0
  assign vld_d = {vld_q[5:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload stages advance every cycle; the valid bits mark live items
  always_ff @(posedge clk_i) begin
    ctl1_q  <= ctl1_d;
    w1_q    <= w1_d;
    raw1_q  <= raw_length_i;

    ctl2_q  <= ctl1_q;
    w2_q    <= w1_q;
    raw2_q  <= raw1_q;
    prod2_q <= prod2_d;

    ctl3_q  <= ctl2_q;
    raw3_q  <= raw2_q;
    q3_q    <= q3_d;
    r3_q    <= r3_d;

    ctl4_q  <= ctl3_q;
    raw4_q  <= raw3_q;
    q4_q    <= q4_d;
    r4_q    <= r4_d;

    ctl5_q  <= ctl4_q;
    bits5_q <= bits5_d;

    ctl6_q  <= ctl5_q;
    cc6_q   <= cc6_d;

    len_q   <= len_d;
  end

  assign busy_o         = 1'b0;
  assign done_o         = vld_q[6];
  assign coded_length_o = len_q;

endmodule
